// ===== src/hashed_buffer_cache_lru_core_assert.svh =====
// Assertion macros for the buffer cache core
`ifndef HASHED_BUFFER_CACHE_LRU_CORE_ASSERT_SVH
`define HASHED_BUFFER_CACHE_LRU_CORE_ASSERT_SVH

// Check an implication on every clock edge outside reset
`define HBC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check an implication in the cycle after the antecedent
`define HBC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/hbcl_pkg.sv =====
// Shared types and constants for the buffer cache core
`default_nettype none
package hbcl_pkg;

    typedef enum logic [1:0] {
        ACT_GET     = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_PIN     = 2'd2,
        ACT_UNPIN   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_FREE  = 2'd1,
        ST_ZERO     = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HASH,
        S_SEARCH,
        S_HIT,
        S_SCAN_BKT,
        S_SCAN,
        S_UNLINK,
        S_PUSH,
        S_SLOT_OP,
        S_DONE,
        S_INIT
    } state_t;

    localparam logic [7:0] COUNT_MAX = 8'd255;
    localparam int unsigned HASH_MUL = 10;

endpackage
`default_nettype wire

// ===== src/hbcl_mod.sv =====
// Modulo unit: folds a 32-bit value by byte residues and finishes with a constant residue table
`default_nettype none
module hbcl_mod
    import hbcl_pkg::*;
#(
    parameter int unsigned DIV = 13
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] value,
    output logic             done,
    output logic [6:0]       rem
);
    // Weights of bytes one, two and three, each already reduced by the divisor
    localparam logic [15:0] W1 = 16'(256 % DIV);
    localparam logic [15:0] W2 = 16'(65536 % DIV);
    localparam logic [15:0] W3 = 16'(16777216 % DIV);

    logic [15:0] acc_reg;
    logic        busy_reg;
    logic [15:0] first_sum;
    logic [15:0] fold_sum;

    // Weight each byte by its residue and add
    assign first_sum = 16'(value[7:0]) + 16'(value[15:8]) * W1
                     + 16'(value[23:16]) * W2 + 16'(value[31:24]) * W3;

    // Fold the high byte back in until only the low byte is left
    assign fold_sum = 16'(acc_reg[7:0]) + 16'(acc_reg[15:8]) * W1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else if (start)
            busy_reg <= 1'b1;
        else if (busy_reg && acc_reg[15:8] == 8'd0)
            busy_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (start)
            acc_reg <= first_sum;
        else if (busy_reg && acc_reg[15:8] != 8'd0)
            acc_reg <= fold_sum;
    end

    assign done = busy_reg && (acc_reg[15:8] == 8'd0);

    // Reduce the last byte through a constant residue table
    always_comb
    begin
        rem = '0;
        for (int i = 0; i < 256; i++)
            if (acc_reg[7:0] == 8'(i))
                rem = 7'(i % DIV);
    end
endmodule
`default_nettype wire

// ===== src/hashed_buffer_cache_lru_core.sv =====
// Top level: hashed buffer cache with per-bucket most-recent-first lists
// Release, pin and unpin pass through a slot-operation step before the result register. A get
// first folds the hash, then visits the slots of its home bucket and on a miss scans the
// buckets from the home bucket on. One beat at a time: the next input is taken once
// the sequencer is idle; a result waiting in the output register stalls only the last step.
// After reset a chain-building pass over every slot runs with in_ready low.
`default_nettype none
`include "hashed_buffer_cache_lru_core_assert.svh"
module hashed_buffer_cache_lru_core
    import hbcl_pkg::*;
#(
    parameter int unsigned BUFFERS = 32,
    parameter int unsigned BUCKETS = 13
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  action,
    input  wire logic [7:0]  dev,
    input  wire logic [31:0] blockno,
    input  wire logic [4:0]  slot,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [4:0]       granted_slot,
    output logic             hit,
    output logic             needs_read,
    output logic [1:0]       status
);
    localparam int unsigned SW = $clog2(BUFFERS + 1);
    localparam int unsigned SI = (BUFFERS > 1) ? $clog2(BUFFERS) : 1;
    localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam logic [SW-1:0] NIL = SW'(BUFFERS);

    // Slot tables
    logic [7:0]    tdev_mem [BUFFERS];
    logic [31:0]   tblk_mem [BUFFERS];
    logic [7:0]    cnt_mem  [BUFFERS];
    logic          vld_mem  [BUFFERS];
    logic [SW-1:0] nxt_mem  [BUFFERS];
    logic [SW-1:0] prv_mem  [BUFFERS];
    logic [SW-1:0] head_mem [BUCKETS];
    logic [SW-1:0] tail_mem [BUCKETS];

    state_t state_reg, state_next;
    logic [1:0]    act_reg;
    logic [7:0]    dev_reg;
    logic [31:0]   blk_reg;
    logic [SW-1:0] cur_reg, cur_next;
    logic [BW-1:0] home_reg, bkt_reg, bkt_next;
    logic [SW-1:0] steps_reg, steps_next;
    logic [BW:0]   nb_reg, nb_next;
    logic          hit_reg, nr_reg;
    logic [1:0]    st_reg;
    logic [4:0]    gs_reg;
    logic          ov_reg;
    logic          out_load;
    logic [4:0]    out_gs_reg;
    logic          out_hit_reg, out_nr_reg;
    logic [1:0]    out_st_reg;
    logic [SI-1:0] ci;
    logic          mod_start, mod_done;
    logic [6:0]    mod_rem;
    logic [31:0]   hash_in;

    assign ci = cur_reg[SI-1:0];
    assign hash_in = 32'(dev * 32'(HASH_MUL)) + blockno;

    hbcl_mod #(.DIV(BUCKETS)) u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mod_start),
        .value (hash_in),
        .done  (mod_done),
        .rem   (mod_rem)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ov_reg;
    assign out_load  = (state_reg == S_DONE) && (!ov_reg || out_ready);
    assign granted_slot = out_gs_reg;
    assign hit = out_hit_reg;
    assign needs_read = out_nr_reg;
    assign status = out_st_reg;
    assign mod_start = in_valid && in_ready && (action == ACT_GET);

    // Hold the state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_INIT;
        else
            state_reg <= state_next;
    end

    // Sequence through the phases of one beat
    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        bkt_next   = bkt_reg;
        steps_next = steps_reg;
        nb_next    = nb_reg;
        case (state_reg)
            S_INIT:
            begin
                cur_next = cur_reg + 1'b1;
                if (cur_reg == SW'(BUFFERS - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
                if (in_valid && in_ready)
                begin
                    state_next = (action == ACT_GET) ? S_HASH : S_SLOT_OP;
                    cur_next   = (32'(slot) >= 32'(BUFFERS)) ? NIL : SW'(slot);
                end
            S_HASH:
                if (mod_done)
                begin
                    cur_next   = head_mem[BW'(mod_rem)];
                    steps_next = '0;
                    state_next = S_SEARCH;
                end
            S_SEARCH:
                if (cur_reg >= NIL || steps_reg == NIL)
                begin
                    bkt_next   = home_reg;
                    nb_next    = '0;
                    state_next = S_SCAN_BKT;
                end
                else if (tdev_mem[ci] == dev_reg && tblk_mem[ci] == blk_reg)
                    state_next = S_HIT;
                else
                begin
                    cur_next   = nxt_mem[ci];
                    steps_next = steps_reg + 1'b1;
                end
            S_HIT:
                state_next = (cnt_mem[ci] >= COUNT_MAX) ? S_DONE : S_UNLINK;
            S_SCAN_BKT:
                if (nb_reg == (BW+1)'(BUCKETS))
                    state_next = S_DONE;
                else
                begin
                    cur_next   = tail_mem[bkt_reg];
                    steps_next = '0;
                    state_next = S_SCAN;
                end
            S_SCAN:
                if (cur_reg >= NIL || steps_reg == NIL)
                begin
                    bkt_next   = (bkt_reg == BW'(BUCKETS - 1)) ? '0 : bkt_reg + 1'b1;
                    nb_next    = nb_reg + 1'b1;
                    state_next = S_SCAN_BKT;
                end
                else if (cnt_mem[ci] == 8'd0)
                    state_next = S_UNLINK;
                else
                begin
                    cur_next   = prv_mem[ci];
                    steps_next = steps_reg + 1'b1;
                end
            S_UNLINK:
                state_next = S_PUSH;
            S_PUSH:
                state_next = S_DONE;
            S_SLOT_OP:
                state_next = S_DONE;
            S_DONE:
                if (!ov_reg || out_ready)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // Advance the datapath registers and drive the result beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg  <= 1'b0;
            cur_reg <= '0;
        end
        else
        begin
            cur_reg <= cur_next;
            if (out_load)
                ov_reg <= 1'b1;
            else if (out_valid && out_ready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        bkt_reg   <= bkt_next;
        steps_reg <= steps_next;
        nb_reg    <= nb_next;
        if (state_reg == S_IDLE && in_valid && in_ready)
        begin
            act_reg <= action;
            dev_reg <= dev;
            blk_reg <= blockno;
            gs_reg  <= slot;
            hit_reg <= 1'b0;
            nr_reg  <= 1'b0;
            st_reg  <= ST_OK;
        end
        if (state_reg == S_HASH && mod_done)
            home_reg <= BW'(mod_rem);
        if (state_reg == S_HIT)
        begin
            hit_reg <= 1'b1;
            gs_reg  <= 5'(cur_reg);
            if (cnt_mem[ci] >= COUNT_MAX)
                st_reg <= ST_OVERFLOW;
            else
                nr_reg <= !vld_mem[ci];
        end
        if (state_reg == S_SCAN && cur_reg < NIL && steps_reg != NIL && cnt_mem[ci] == 8'd0)
        begin
            gs_reg <= 5'(cur_reg);
            nr_reg <= 1'b1;
        end
        if (state_reg == S_SCAN_BKT && nb_reg == (BW+1)'(BUCKETS))
        begin
            gs_reg <= '0;
            st_reg <= ST_NO_FREE;
        end
        if (state_reg == S_SLOT_OP)
        begin
            if (cur_reg >= NIL || cnt_mem[ci] == 8'd0)
                st_reg <= ST_ZERO;
            else if (act_reg == ACT_PIN && cnt_mem[ci] >= COUNT_MAX)
                st_reg <= ST_OVERFLOW;
        end
        // Hand the finished result to the output register
        if (out_load)
        begin
            out_gs_reg  <= gs_reg;
            out_hit_reg <= hit_reg;
            out_nr_reg  <= nr_reg;
            out_st_reg  <= st_reg;
        end
    end

    // Update the tables: build the chain, relink, retag and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_mem <= '{default: NIL};
            tail_mem <= '{default: NIL};
        end
        else
        begin
            case (state_reg)
                S_INIT:
                begin
                    tdev_mem[ci] <= '0;
                    tblk_mem[ci] <= '0;
                    cnt_mem[ci]  <= '0;
                    vld_mem[ci]  <= 1'b0;
                    prv_mem[ci]  <= (cur_reg == SW'(BUFFERS - 1)) ? NIL : cur_reg + 1'b1;
                    nxt_mem[ci]  <= (cur_reg == '0) ? NIL : cur_reg - 1'b1;
                    if (cur_reg == '0)
                        tail_mem[0] <= '0;
                    if (cur_reg == SW'(BUFFERS - 1))
                        head_mem[0] <= cur_reg;
                end
                S_UNLINK:
                begin
                    if (hit_reg)
                        cnt_mem[ci] <= cnt_mem[ci] + 8'd1;
                    else
                    begin
                        cnt_mem[ci]  <= 8'd1;
                        tdev_mem[ci] <= dev_reg;
                        tblk_mem[ci] <= blk_reg;
                    end
                    vld_mem[ci] <= 1'b1;
                    if (prv_mem[ci] < NIL)
                        nxt_mem[prv_mem[ci][SI-1:0]] <= nxt_mem[ci];
                    else
                        head_mem[hit_reg ? home_reg : bkt_reg] <= nxt_mem[ci];
                    if (nxt_mem[ci] < NIL)
                        prv_mem[nxt_mem[ci][SI-1:0]] <= prv_mem[ci];
                    else
                        tail_mem[hit_reg ? home_reg : bkt_reg] <= prv_mem[ci];
                end
                S_PUSH:
                begin
                    prv_mem[ci] <= NIL;
                    nxt_mem[ci] <= head_mem[home_reg];
                    if (head_mem[home_reg] < NIL)
                        prv_mem[head_mem[home_reg][SI-1:0]] <= cur_reg;
                    else
                        tail_mem[home_reg] <= cur_reg;
                    head_mem[home_reg] <= cur_reg;
                end
                S_SLOT_OP:
                    if (cur_reg < NIL && cnt_mem[ci] != 8'd0)
                    begin
                        if (act_reg == ACT_PIN)
                        begin
                            if (cnt_mem[ci] < COUNT_MAX)
                                cnt_mem[ci] <= cnt_mem[ci] + 8'd1;
                        end
                        else
                            cnt_mem[ci] <= cnt_mem[ci] - 8'd1;
                    end
                default:
                    ;
            endcase
        end
    end

    `HBC_ASSERT_IMP(a_ready_idle, in_ready, state_reg == S_IDLE)
    `HBC_ASSERT_NEXT(a_done_valid, state_reg == S_DONE, out_valid)
    `HBC_ASSERT_IMP(a_nofree_gs, out_valid && status == ST_NO_FREE, granted_slot == 5'd0 && !hit)
    `HBC_ASSERT_IMP(a_nr_ok, out_valid && needs_read, status == ST_OK)
endmodule
`default_nettype wire
